// ===== src/tmac_pkg.sv =====
// shared types, codes and constants of the tracker motor angle controller
package tmac_pkg;

  // angle fields, two's complement, hundredths of a degree
  localparam int AngleBits = 16;

  // configuration port
  localparam int CfgDataW = (AngleBits > 16) ? AngleBits : 16;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] RegTrackingAccuracy = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSwitchDelayLimit = 3'd1;
  localparam logic [CfgIdxW-1:0] RegRunTimeLimit     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPivotAngle       = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAutoTrackerCode  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAutoAiCode       = 3'd5;

  // register reset values
  localparam logic [14:0]          TrackingAccuracyReset = 15'd100;
  localparam logic [7:0]           SwitchDelayLimitReset = 8'd200;
  localparam logic [15:0]          RunTimeLimitReset     = 16'd2000;
  localparam logic [AngleBits-1:0] PivotAngleReset       = AngleBits'(9000);
  localparam logic [7:0]           AutoTrackerCodeReset  = 8'd1;
  localparam logic [7:0]           AutoAiCodeReset       = 8'd2;

  // move state codes
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StEast   = 2'd1;
  localparam logic [1:0] StWest   = 2'd2;

  // direction codes
  localparam logic [1:0] DirNone  = 2'd0;
  localparam logic [1:0] DirEast  = 2'd1;
  localparam logic [1:0] DirWest  = 2'd2;

  // motor command codes
  localparam logic [1:0] CmdNone  = 2'd0;
  localparam logic [1:0] CmdStop  = 2'd1;
  localparam logic [1:0] CmdEast  = 2'd2;
  localparam logic [1:0] CmdWest  = 2'd3;

  // supply request codes
  localparam logic [1:0] SupNone  = 2'd0;
  localparam logic [1:0] SupBat   = 2'd1;
  localparam logic [1:0] SupPv    = 2'd2;

  typedef struct packed {
    logic [AngleBits-1:0] target_angle;
    logic [AngleBits-1:0] actual_angle;
    logic                 motor_enable;
    logic [5:0]           fault_flags;
    logic                 east_soft_limit;
    logic                 west_soft_limit;
    logic                 need_lead;
    logic [7:0]           work_mode;
  } in_t;

  typedef struct packed {
    logic [1:0] motor_command;
    logic [1:0] requested_direction;
    logic [1:0] supply_request;
    logic [1:0] control_state;
  } out_t;

  typedef struct packed {
    logic [14:0]          tracking_accuracy;
    logic [7:0]           switch_delay_limit;
    logic [15:0]          run_time_limit;
    logic [AngleBits-1:0] pivot_angle;
    logic [7:0]           auto_tracker_code;
    logic [7:0]           auto_ai_code;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  move_state;
    logic [1:0]  pending_direction;
    logic [7:0]  switch_delay_count;
    logic [15:0] run_time_count;
  } state_t;

endpackage

// ===== src/tmac_cfg_regs.sv =====
// configuration register file of the tracker motor angle controller
module tmac_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tmac_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [tmac_pkg::CfgDataW-1:0] cfg_data_i,
  output tmac_pkg::cfg_t               cfg_o
);

  tmac_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmac_pkg::RegTrackingAccuracy: cfg_d.tracking_accuracy  = cfg_data_i[14:0];
        tmac_pkg::RegSwitchDelayLimit: cfg_d.switch_delay_limit = cfg_data_i[7:0];
        tmac_pkg::RegRunTimeLimit:     cfg_d.run_time_limit     = cfg_data_i[15:0];
        tmac_pkg::RegPivotAngle:
          cfg_d.pivot_angle = cfg_data_i[tmac_pkg::AngleBits-1:0];
        tmac_pkg::RegAutoTrackerCode:  cfg_d.auto_tracker_code  = cfg_data_i[7:0];
        tmac_pkg::RegAutoAiCode:       cfg_d.auto_ai_code       = cfg_data_i[7:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tracking_accuracy  <= tmac_pkg::TrackingAccuracyReset;
      cfg_q.switch_delay_limit <= tmac_pkg::SwitchDelayLimitReset;
      cfg_q.run_time_limit     <= tmac_pkg::RunTimeLimitReset;
      cfg_q.pivot_angle        <= tmac_pkg::PivotAngleReset;
      cfg_q.auto_tracker_code  <= tmac_pkg::AutoTrackerCodeReset;
      cfg_q.auto_ai_code       <= tmac_pkg::AutoAiCodeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/tmac_step.sv =====
// per-tick control logic: move state machine, counters and supply choice
module tmac_step (
  input  tmac_pkg::cfg_t   cfg_i,
  input  tmac_pkg::state_t state_i,
  input  tmac_pkg::in_t    in_i,
  output tmac_pkg::state_t state_o,
  output tmac_pkg::out_t   out_o
);

  localparam int AW   = tmac_pkg::AngleBits;
  // room for the angle difference and the 15 bit accuracy, plus a sign
  localparam int CmpW = ((AW + 2) > 17) ? (AW + 2) : 17;

  logic signed [CmpW-1:0] tgt_x, act_x, diff, neg_diff;
  logic signed [CmpW-1:0] acc_x, neg_acc, lead_x;
  logic                   run_ok;
  logic                   go;
  logic                   mode_auto;
  logic                   act_lt_pivot, act_gt_pivot;
  logic [7:0]             sdc_inc;
  logic [15:0]            rtc_inc;
  tmac_pkg::state_t       st;
  logic [1:0]             cmd;
  logic [1:0]             supply;

  assign tgt_x    = {{(CmpW-AW){in_i.target_angle[AW-1]}}, in_i.target_angle};
  assign act_x    = {{(CmpW-AW){in_i.actual_angle[AW-1]}}, in_i.actual_angle};
  assign diff     = tgt_x - act_x;
  assign neg_diff = act_x - tgt_x;
  assign acc_x    = {{(CmpW-15){1'b0}}, cfg_i.tracking_accuracy};
  assign neg_acc  = -acc_x;
  // lead angle is half the accuracy, truncated
  assign lead_x   = in_i.need_lead ? {{(CmpW-14){1'b0}}, cfg_i.tracking_accuracy[14:1]}
                                   : '0;

  assign run_ok    = in_i.motor_enable && (in_i.fault_flags == 6'd0);
  assign go        = state_i.switch_delay_count > cfg_i.switch_delay_limit;
  assign sdc_inc   = state_i.switch_delay_count + 8'd1;
  assign rtc_inc   = state_i.run_time_count + 16'd1;
  assign mode_auto = (in_i.work_mode == cfg_i.auto_tracker_code) ||
                     (in_i.work_mode == cfg_i.auto_ai_code);
  assign act_lt_pivot = $signed(in_i.actual_angle) < $signed(cfg_i.pivot_angle);
  assign act_gt_pivot = $signed(in_i.actual_angle) > $signed(cfg_i.pivot_angle);

  always_comb begin
    st     = state_i;
    cmd    = tmac_pkg::CmdNone;
    supply = tmac_pkg::SupNone;

    if (run_ok) begin
      unique case (state_i.move_state)
        tmac_pkg::StIdle: begin
          if (diff > acc_x) begin
            st.pending_direction  = tmac_pkg::DirWest;
            st.switch_delay_count = go ? 8'd0 : sdc_inc;
            if (go) st.move_state = tmac_pkg::StWest;
          end else if (diff < neg_acc) begin
            st.pending_direction  = tmac_pkg::DirEast;
            st.switch_delay_count = go ? 8'd0 : sdc_inc;
            if (go) st.move_state = tmac_pkg::StEast;
          end else begin
            cmd                   = tmac_pkg::CmdStop;
            st.switch_delay_count = 8'd0;
            st.pending_direction  = tmac_pkg::DirNone;
          end
        end
        tmac_pkg::StEast: begin
          if ((diff >= lead_x) || in_i.east_soft_limit) begin
            cmd               = tmac_pkg::CmdStop;
            st.move_state     = tmac_pkg::StIdle;
            st.run_time_count = 16'd0;
          end else begin
            cmd               = tmac_pkg::CmdEast;
            st.run_time_count = rtc_inc;
          end
        end
        tmac_pkg::StWest: begin
          if ((neg_diff >= lead_x) || in_i.west_soft_limit) begin
            cmd               = tmac_pkg::CmdStop;
            st.move_state     = tmac_pkg::StIdle;
            st.run_time_count = 16'd0;
          end else begin
            cmd               = tmac_pkg::CmdWest;
            st.run_time_count = rtc_inc;
          end
        end
        default: begin
          // unused state code falls back to idle
          cmd               = tmac_pkg::CmdStop;
          st.move_state     = tmac_pkg::StIdle;
          st.run_time_count = 16'd0;
        end
      endcase
    end else begin
      cmd                  = tmac_pkg::CmdStop;
      st.move_state        = tmac_pkg::StIdle;
      st.pending_direction = tmac_pkg::DirNone;
      st.run_time_count    = 16'd0;
    end

    if (st.run_time_count > cfg_i.run_time_limit) begin
      st.run_time_count = 16'd0;
      supply            = tmac_pkg::SupBat;
    end

    if (st.move_state == tmac_pkg::StIdle) begin
      priority if (st.pending_direction == tmac_pkg::DirNone) begin
        supply = tmac_pkg::SupPv;
      end else if (!mode_auto) begin
        supply = tmac_pkg::SupBat;
      end else if (st.pending_direction == tmac_pkg::DirWest) begin
        supply = act_lt_pivot ? tmac_pkg::SupBat : tmac_pkg::SupPv;
      end else if (st.pending_direction == tmac_pkg::DirEast) begin
        supply = act_gt_pivot ? tmac_pkg::SupBat : tmac_pkg::SupPv;
      end
    end
  end

  assign state_o                   = st;
  assign out_o.motor_command       = cmd;
  assign out_o.requested_direction = st.pending_direction;
  assign out_o.supply_request      = supply;
  assign out_o.control_state       = st.move_state;

endmodule

// ===== src/tracker_motor_angle_controller_unit.sv =====
// top level of the tracker motor angle controller
// one control tick per beat: a beat is taken into an input register, the tick logic runs
// between that register and the result register, which offers the result beat; while the
// result side does not stall, a new beat is accepted every cycle, so the sustained rate is
// one tick per clock, set by the single pass from the input register through the
// move state machine and counters to the result register; the controller state advances
// when a tick moves into the result register, and a stalled result holds only the input
// register once both stages are full; configuration is written through a plain write port
// (index 0 accuracy, 1 switch delay limit, 2 run time limit, 3 pivot angle, 4 and 5 the
// automatic work mode codes) and should only change while no ticks are in flight
module tracker_motor_angle_controller_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tmac_pkg::in_t                 in_data_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tmac_pkg::out_t                out_data_o,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tmac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tmac_pkg::CfgDataW-1:0] cfg_data_i
);

  tmac_pkg::cfg_t   cfg;
  tmac_pkg::state_t state_q, state_d;
  tmac_pkg::in_t    in_q;
  tmac_pkg::out_t   out_q, step_out;
  logic             in_valid_q, in_valid_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;   // result register can take a beat
  logic             adv;        // tick moves from input to result register
  logic             in_take;

  tmac_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  tmac_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .in_i    (in_q),
    .state_o (state_d),
    .out_o   (step_out)
  );

  // handshake between the two stages
  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv         = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !adv;
  assign in_take     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_take || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_data_i;
    if (adv) out_q <= step_out;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // while moving, the pending direction matches the move direction
  a_move_dir : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.control_state != tmac_pkg::StIdle) |->
      out_data_o.requested_direction == out_data_o.control_state)
    else $error("moving without matching pending direction");

  // a turn command only comes with the matching move state
  a_turn_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.motor_command == tmac_pkg::CmdEast ||
                     out_data_o.motor_command == tmac_pkg::CmdWest)) |->
      ((out_data_o.motor_command == tmac_pkg::CmdEast &&
        out_data_o.control_state == tmac_pkg::StEast) ||
       (out_data_o.motor_command == tmac_pkg::CmdWest &&
        out_data_o.control_state == tmac_pkg::StWest)))
    else $error("turn command without matching move state");

  // idle always names a supply
  a_idle_supply : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.control_state == tmac_pkg::StIdle) |->
      out_data_o.supply_request != tmac_pkg::SupNone)
    else $error("idle result without supply request");

  // input stalls only while both the input and the result register hold a tick
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with free pipeline stage");

endmodule

// ===== verif/tmac_checker.sv =====
// checker for the tracker motor angle controller: predicts each tick result and compares
module tmac_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  tmac_pkg::in_t                 in_beat_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  tmac_pkg::out_t                out_beat_i,
  input  logic                          cfg_we_i,
  input  logic [tmac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tmac_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            results_waiting_o
);

  tmac_pkg::cfg_t   ctrl_cfg;
  tmac_pkg::state_t ctrl_st;
  tmac_pkg::out_t   expected_ticks[$];
  tmac_pkg::out_t   predicted;
  tmac_pkg::out_t   oldest;
  int               fails = 0;

  // one control tick of the controller, updates the local state copy
  task automatic advance_controller(input tmac_pkg::in_t b, output tmac_pkg::out_t r);
    int         target;
    int         actual;
    int         diff;
    int         acc;
    int         lead;
    int         pivot;
    logic [1:0] cmd;
    logic [1:0] sup;
    logic       go;
    target = int'($signed(b.target_angle));
    actual = int'($signed(b.actual_angle));
    diff   = target - actual;
    acc    = int'(ctrl_cfg.tracking_accuracy);
    pivot  = int'($signed(ctrl_cfg.pivot_angle));
    lead   = b.need_lead ? int'(ctrl_cfg.tracking_accuracy >> 1) : 0;
    cmd    = tmac_pkg::CmdNone;
    sup    = tmac_pkg::SupNone;
    if (b.motor_enable && b.fault_flags == '0) begin
      case (ctrl_st.move_state)
        tmac_pkg::StIdle: begin
          if (diff > acc || diff < -acc) begin
            // compare first, then count
            go = ctrl_st.switch_delay_count > ctrl_cfg.switch_delay_limit;
            ctrl_st.pending_direction  = (diff > acc) ? tmac_pkg::DirWest : tmac_pkg::DirEast;
            ctrl_st.switch_delay_count = ctrl_st.switch_delay_count + 8'd1;
            if (go) begin
              ctrl_st.move_state         = (diff > acc) ? tmac_pkg::StWest : tmac_pkg::StEast;
              ctrl_st.switch_delay_count = '0;
            end
          end else begin
            cmd                        = tmac_pkg::CmdStop;
            ctrl_st.switch_delay_count = '0;
            ctrl_st.pending_direction  = tmac_pkg::DirNone;
          end
        end
        tmac_pkg::StEast: begin
          if (diff >= lead || b.east_soft_limit) begin
            cmd                    = tmac_pkg::CmdStop;
            ctrl_st.move_state     = tmac_pkg::StIdle;
            ctrl_st.run_time_count = '0;
          end else begin
            ctrl_st.run_time_count = ctrl_st.run_time_count + 16'd1;
            cmd                    = tmac_pkg::CmdEast;
          end
        end
        tmac_pkg::StWest: begin
          if (-diff >= lead || b.west_soft_limit) begin
            cmd                    = tmac_pkg::CmdStop;
            ctrl_st.move_state     = tmac_pkg::StIdle;
            ctrl_st.run_time_count = '0;
          end else begin
            ctrl_st.run_time_count = ctrl_st.run_time_count + 16'd1;
            cmd                    = tmac_pkg::CmdWest;
          end
        end
        default: begin
          cmd                    = tmac_pkg::CmdStop;
          ctrl_st.move_state     = tmac_pkg::StIdle;
          ctrl_st.run_time_count = '0;
        end
      endcase
    end else begin
      cmd                       = tmac_pkg::CmdStop;
      ctrl_st.move_state        = tmac_pkg::StIdle;
      ctrl_st.pending_direction = tmac_pkg::DirNone;
      ctrl_st.run_time_count    = '0;
    end

    if (ctrl_st.run_time_count > ctrl_cfg.run_time_limit) begin
      ctrl_st.run_time_count = '0;
      sup                    = tmac_pkg::SupBat;
    end

    if (ctrl_st.move_state == tmac_pkg::StIdle) begin
      if (ctrl_st.pending_direction != tmac_pkg::DirNone) begin
        if (b.work_mode != ctrl_cfg.auto_tracker_code &&
            b.work_mode != ctrl_cfg.auto_ai_code) begin
          sup = tmac_pkg::SupBat;
        end else if (ctrl_st.pending_direction == tmac_pkg::DirWest) begin
          sup = (actual < pivot) ? tmac_pkg::SupBat : tmac_pkg::SupPv;
        end else if (ctrl_st.pending_direction == tmac_pkg::DirEast) begin
          sup = (actual > pivot) ? tmac_pkg::SupBat : tmac_pkg::SupPv;
        end
      end else begin
        sup = tmac_pkg::SupPv;
      end
    end

    r.motor_command       = cmd;
    r.requested_direction = ctrl_st.pending_direction;
    r.supply_request      = sup;
    r.control_state       = ctrl_st.move_state;
  endtask

  task automatic report_field(input string name, input logic [1:0] exp, input logic [1:0] got);
    if (exp !== got) begin
      fails++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_cfg.tracking_accuracy  = tmac_pkg::TrackingAccuracyReset;
      ctrl_cfg.switch_delay_limit = tmac_pkg::SwitchDelayLimitReset;
      ctrl_cfg.run_time_limit     = tmac_pkg::RunTimeLimitReset;
      ctrl_cfg.pivot_angle        = tmac_pkg::PivotAngleReset;
      ctrl_cfg.auto_tracker_code  = tmac_pkg::AutoTrackerCodeReset;
      ctrl_cfg.auto_ai_code       = tmac_pkg::AutoAiCodeReset;
      ctrl_st                     = '0;
      expected_ticks.delete();
      results_waiting_o           <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tmac_pkg::RegTrackingAccuracy:
            ctrl_cfg.tracking_accuracy  = cfg_data_i[14:0];
          tmac_pkg::RegSwitchDelayLimit:
            ctrl_cfg.switch_delay_limit = cfg_data_i[7:0];
          tmac_pkg::RegRunTimeLimit:
            ctrl_cfg.run_time_limit     = cfg_data_i[15:0];
          tmac_pkg::RegPivotAngle:
            ctrl_cfg.pivot_angle        = cfg_data_i[tmac_pkg::AngleBits-1:0];
          tmac_pkg::RegAutoTrackerCode:
            ctrl_cfg.auto_tracker_code  = cfg_data_i[7:0];
          tmac_pkg::RegAutoAiCode:
            ctrl_cfg.auto_ai_code       = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_ticks.size() == 0) begin
          fails++;
          $display("%0t: result beat with nothing expected, got %h", $time, out_beat_i);
        end else begin
          oldest = expected_ticks.pop_front();
          report_field("motor_command", oldest.motor_command, out_beat_i.motor_command);
          report_field("requested_direction", oldest.requested_direction,
                       out_beat_i.requested_direction);
          report_field("supply_request", oldest.supply_request, out_beat_i.supply_request);
          report_field("control_state", oldest.control_state, out_beat_i.control_state);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        advance_controller(in_beat_i, predicted);
        expected_ticks.push_back(predicted);
      end
      results_waiting_o <= expected_ticks.size();
      fail_count_o      <= fails;
    end
  end

endmodule

// ===== verif/testbench.sv =====
// top of the tracker motor angle controller testbench: stimulus, stall patterns and verdict
module testbench;

  localparam int IdxW   = tmac_pkg::CfgIdxW;
  localparam int DataW  = tmac_pkg::CfgDataW;
  localparam int AngleW = tmac_pkg::AngleBits;

  // run limit in clock cycles, far above the slowest correct run
  localparam int CycleLimit = 1_000_000;
  // length of the long receiver hold-off
  localparam int HoldCycles = 300;
  // register indexes past the last register, written to see that they do nothing
  localparam logic [IdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [IdxW-1:0] RegSpareHi = 3'd7;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  tmac_pkg::in_t    in_beat;
  logic             out_valid;
  logic             out_stall;
  tmac_pkg::out_t   out_beat;
  logic             cfg_we;
  logic [IdxW-1:0]  cfg_idx;
  logic [DataW-1:0] cfg_data;
  int               fail_count;
  int               results_waiting;

  int cycle_count     = 0;
  int beats_sent      = 0;
  int rx_holds_asked  = 0;
  int rx_holds_done   = 0;
  bit tx_calm         = 1'b0;
  bit rx_calm         = 1'b0;

  // stimulus-side copy of the settings that shape the tick sequences
  int         acc_now   = 100;
  int         delay_now = 200;
  logic [7:0] mode_a    = 8'd1;
  logic [7:0] mode_b    = 8'd2;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tracker_motor_angle_controller_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  tmac_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_beat_i         (in_beat),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_beat_i        (out_beat),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .results_waiting_o (results_waiting)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL tracker_motor_angle_controller_unit");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int gap_len(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic int clamp_angle(input int a);
    if (a > 32767) return 32767;
    if (a < -32768) return -32768;
    return a;
  endfunction

  // mostly one of the automatic work modes, sometimes any code
  function automatic logic [7:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return mode_a;
    if (r < 70) return mode_b;
    return 8'($urandom);
  endfunction

  // result side: random stalls, plus a long hold-off whenever the stimulus asks for one
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_holds_done != rx_holds_asked) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        rx_holds_done++;
      end else begin
        int stall_len;
        stall_len = gap_len(rx_calm);
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // offer one tick beat and hold it until taken; valid stays up when no gap follows
  task automatic send_beat(input tmac_pkg::in_t b);
    int gap;
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    gap = gap_len(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drive_tick(input int target, input int actual, input bit en,
                            input logic [5:0] faults, input bit east, input bit west,
                            input bit lead, input logic [7:0] mode);
    tmac_pkg::in_t b;
    b.target_angle    = AngleW'(target);
    b.actual_angle    = AngleW'(actual);
    b.motor_enable    = en;
    b.fault_flags     = faults;
    b.east_soft_limit = east;
    b.west_soft_limit = west;
    b.need_lead       = lead;
    b.work_mode       = mode;
    send_beat(b);
  endtask

  // tick of a tracking run with a little noise: dropouts, faults, soft limits
  task automatic sequence_tick(input int target, input int actual, input int dir,
                               input bit lead, input logic [7:0] mode);
    logic [5:0] faults;
    bit         east;
    bit         west;
    faults = ($urandom_range(0, 49) == 0) ? 6'($urandom_range(1, 63)) : 6'd0;
    // the limit in the travel direction shows up more often
    east   = (dir < 0) ? ($urandom_range(0, 29) == 0) : ($urandom_range(0, 99) == 0);
    west   = (dir > 0) ? ($urandom_range(0, 29) == 0) : ($urandom_range(0, 99) == 0);
    drive_tick(target, actual, $urandom_range(0, 99) != 0, faults, east, west, lead, mode);
  endtask

  // one tracking run: error outside the deadband long enough to start the motor,
  // then the actual angle walks toward the target and past it
  task automatic track_sequence();
    int         target;
    int         actual;
    int         span;
    int         dir;
    int         step;
    int         hold;
    int         moves;
    bit         lead;
    logic [7:0] mode;
    target = int'($urandom_range(0, 50000)) - 25000;
    span   = acc_now + 1 + int'($urandom_range(0, 200));
    if ($urandom_range(0, 3) == 0) span += int'($urandom_range(0, 20000));
    dir    = $urandom_range(0, 1) ? 1 : -1;
    actual = clamp_angle(target - dir * span);
    lead   = 1'($urandom_range(0, 1));
    mode   = pick_mode();
    hold   = delay_now + 2 + int'($urandom_range(0, 2));
    // sometimes the error goes away before the delay runs out
    if ($urandom_range(0, 9) == 0) hold = $urandom_range(1, hold);
    if ($urandom_range(0, 1)) step = 1 + span / int'($urandom_range(2, 60));
    else step = 1 + int'($urandom_range(0, span / 4));
    repeat (hold) sequence_tick(target, actual, dir, lead, mode);
    moves = 0;
    while (dir * (actual - target) <= acc_now / 2 + 2 && moves < 90) begin
      actual = clamp_angle(actual + dir * step);
      sequence_tick(target, actual, dir, lead, mode);
      moves++;
    end
    repeat ($urandom_range(1, 4)) sequence_tick(target, actual, dir, lead, mode);
  endtask

  task automatic noise_beat();
    logic [63:0]   raw;
    tmac_pkg::in_t b;
    raw = {$urandom, $urandom};
    b   = raw[$bits(tmac_pkg::in_t)-1:0];
    send_beat(b);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write with random junk above the register width
  task automatic write_reg(input logic [IdxW-1:0] idx, input int value, input int width);
    logic [DataW-1:0] mask;
    logic [DataW-1:0] junk;
    mask     = DataW'((64'd1 << width) - 64'd1);
    junk     = DataW'($urandom);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= (junk & ~mask) | (DataW'(value) & mask);
    @(posedge clk);
  endtask

  task automatic configure(input int phase);
    int acc;
    int dly;
    int run;
    int piv;
    int ca;
    int cb;
    case (phase)
      0: begin acc = 100;   dly = 0;   run = 1;     piv = 0;      ca = 1;   cb = 2;   end
      1: begin acc = 0;     dly = 3;   run = 0;     piv = -32768; ca = 255; cb = 0;   end
      2: begin acc = 32767; dly = 1;   run = 20;    piv = 32767;  ca = 0;   cb = 255; end
      // limits at all-ones: never exceeded
      4: begin acc = 200;   dly = 255; run = 65535; piv = 0;      ca = 1;   cb = 2;   end
      5: begin acc = 50;    dly = 254; run = 65534; piv = 9000;   ca = 2;   cb = 1;   end
      // back to the reset settings
      6: begin acc = 100;   dly = 200; run = 2000;  piv = 9000;   ca = 1;   cb = 2;   end
      default: begin
        acc = $urandom_range(0, 400);
        dly = $urandom_range(0, 6);
        run = $urandom_range(0, 40);
        piv = int'($urandom_range(0, 40000)) - 20000;
        ca  = $urandom_range(0, 3);
        cb  = $urandom_range(0, 3);
      end
    endcase
    write_reg(tmac_pkg::RegTrackingAccuracy, acc, 15);
    write_reg(tmac_pkg::RegSwitchDelayLimit, dly, 8);
    write_reg(tmac_pkg::RegRunTimeLimit, run, 16);
    write_reg(tmac_pkg::RegPivotAngle, piv, AngleW);
    write_reg(tmac_pkg::RegAutoTrackerCode, ca, 8);
    write_reg(tmac_pkg::RegAutoAiCode, cb, 8);
    if (phase == 0) begin
      write_reg(RegSpareLo, int'($urandom), DataW);
      write_reg(RegSpareHi, int'($urandom), DataW);
    end
    cfg_we    <= 1'b0;
    acc_now   = acc;
    delay_now = dly;
    mode_a    = 8'(ca);
    mode_b    = 8'(cb);
  endtask

  initial begin
    int quota;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_beat  <= '0;
    cfg_we   <= 1'b0;
    cfg_idx  <= '0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: idle behavior only, the switch delay is long
    drive_tick(0, 0, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);            // disabled
    drive_tick(0, 0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);            // in deadband
    drive_tick(32767, -32768, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);   // west, below pivot
    drive_tick(-32768, 32767, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'hFF);  // east, manual mode
    drive_tick(-32768, 32767, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd2);   // east, above pivot
    drive_tick(-32768, -100, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);    // east, below pivot
    drive_tick(100, 0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);          // error at +accuracy
    drive_tick(0, 100, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);          // error at -accuracy
    drive_tick(20101, 20000, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd2);    // just past deadband
    drive_tick(20101, 20000, 1'b1, 6'h01, 1'b0, 1'b0, 1'b0, 8'd2);   // lowest fault bit
    drive_tick(20101, 20000, 1'b1, 6'h20, 1'b0, 1'b0, 1'b0, 8'd2);   // highest fault bit
    drive_tick(20101, 20000, 1'b0, 6'h3F, 1'b0, 1'b0, 1'b0, 8'd2);   // all faults, disabled
    drive_tick(0, 0, 1'b1, 6'd0, 1'b1, 1'b1, 1'b1, 8'hAA);           // limits and lead idle

    // no switch delay, run limit of one: every move branch in a few ticks
    wait_drained();
    configure(0);
    drive_tick(1000, 0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);         // pending west
    drive_tick(1000, 0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);         // starts west
    drive_tick(1000, 500, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);       // turning west
    drive_tick(1000, 600, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);       // run time exceeded
    drive_tick(1000, 700, 1'b1, 6'd0, 1'b0, 1'b1, 1'b0, 8'd1);       // west limit stop
    drive_tick(0, 1000, 1'b1, 6'd0, 1'b0, 1'b0, 1'b1, 8'd2);         // pending east
    drive_tick(0, 1000, 1'b1, 6'd0, 1'b0, 1'b0, 1'b1, 8'd2);         // starts east
    drive_tick(0, 80, 1'b1, 6'd0, 1'b0, 1'b0, 1'b1, 8'd2);           // short of lead angle
    drive_tick(0, -60, 1'b1, 6'd0, 1'b0, 1'b0, 1'b1, 8'd2);          // lead angle reached
    drive_tick(1000, 0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);
    drive_tick(1000, 0, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0, 8'd1);
    drive_tick(1000, 10, 1'b1, 6'h04, 1'b0, 1'b0, 1'b0, 8'd1);       // fault while moving

    // random phases, each with its own settings
    for (int phase = 0; phase < 8; phase++) begin
      wait_drained();
      configure(phase);
      tx_calm = (phase % 3 == 2);
      rx_calm = (phase % 4 == 3);
      // long receiver hold-off while ticks keep coming, so the input backs up
      if (phase == 1) rx_holds_asked <= rx_holds_asked + 1;
      quota = beats_sent + 190;
      while (beats_sent < quota) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 5)) noise_beat();
        end else begin
          track_sequence();
        end
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS tracker_motor_angle_controller_unit");
    end else begin
      $display("FAIL tracker_motor_angle_controller_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/tmac_pkg.sv
src/tmac_cfg_regs.sv
src/tmac_step.sv
src/tracker_motor_angle_controller_unit.sv
verif/tmac_checker.sv
verif/testbench.sv
